FILE: rtl/synth_frequency_planner_top_assert.svh
// assertion macros used by the bound checker module sfp_checker
`ifndef SYNTH_FREQUENCY_PLANNER_TOP_ASSERT_SVH
`define SYNTH_FREQUENCY_PLANNER_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is high
`define SFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is high
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfp_pkg;

  // field and register widths
  localparam int FREQ_WIDTH = 23;
  localparam int PFD_W      = 17;
  localparam int MOD_W      = 12;
  localparam int WIN_W      = 23;
  localparam int INT_W      = 16;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 2;

  // vco word must hold both the widest request and the top of the vco octave
  localparam int VCO_MIN_W  = 23;
  localparam int VCO_W      = (FREQ_WIDTH > VCO_MIN_W) ? FREQ_WIDTH : VCO_MIN_W;

  // fraction divider: numerator 2*rem*mod + pfd over 2*pfd
  localparam int PROD_W     = PFD_W + MOD_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int DEN_W      = PFD_W + 1;
  localparam int FRAC_QW    = MOD_W;

  // octave thresholds for the output divider
  localparam int NUM_OCT    = 6;
  localparam logic [CODE_W-1:0] MAX_CODE = CODE_W'(NUM_OCT);

  // register reset values
  localparam logic [PFD_W-1:0] PFD_RESET = PFD_W'(25000);
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(4095);
  localparam logic [WIN_W-1:0] MIN_RESET = WIN_W'(34375);
  localparam logic [WIN_W-1:0] MAX_RESET = WIN_W'(4400000);

  localparam logic [INT_W-1:0] INT_SAT = '1;

  typedef logic [VCO_W-1:0] vco_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PFD = 2'd0,
    REG_MOD = 2'd1,
    REG_MIN = 2'd2,
    REG_MAX = 2'd3
  } cfg_reg_t;

  // upper edge of each octave, smallest first
  function automatic vco_t octave_khz(input logic [CODE_W-1:0] idx);
    vco_t thr;
    case (idx)
      3'd0:    thr = vco_t'(68750);
      3'd1:    thr = vco_t'(137500);
      3'd2:    thr = vco_t'(275000);
      3'd3:    thr = vco_t'(550000);
      3'd4:    thr = vco_t'(1100000);
      3'd5:    thr = vco_t'(2200000);
      default: thr = '0;
    endcase
    return thr;
  endfunction

  // word after range check and divider choice
  typedef struct packed {
    logic                 oor;
    logic [CODE_W-1:0]    code;
    vco_t                 vco;
  } prep_t;

  // word inside the integer divider: acc holds dividend bits, then quotient
  typedef struct packed {
    logic                 oor;
    logic [CODE_W-1:0]    code;
    logic [PFD_W-1:0]     rem;
    vco_t                 acc;
  } idiv_t;

  // word after the remainder times modulus product
  typedef struct packed {
    logic                 oor;
    logic [CODE_W-1:0]    code;
    vco_t                 n;
    logic [PROD_W-1:0]    prod;
  } mul_t;

  // word with the rounding numerator
  typedef struct packed {
    logic                 oor;
    logic [CODE_W-1:0]    code;
    vco_t                 n;
    logic [NUM_W-1:0]     num;
  } num_t;

  // word inside the fraction divider
  typedef struct packed {
    logic                 oor;
    logic [CODE_W-1:0]    code;
    vco_t                 n;
    logic [DEN_W-1:0]     rem;
    logic [FRAC_QW-1:0]   acc;
  } fdiv_t;

  // finished plan
  typedef struct packed {
    logic [INT_W-1:0]     integer_part;
    logic [MOD_W-1:0]     fraction;
    logic [CODE_W-1:0]    divider_code;
    logic                 out_of_range;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/sfp_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module sfp_prep (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire logic                           in_valid,
  input  wire logic [sfp_pkg::FREQ_WIDTH-1:0] freq_khz,
  input  wire logic [sfp_pkg::PFD_W-1:0]      pfd_khz,
  input  wire logic [sfp_pkg::WIN_W-1:0]      min_freq_khz,
  input  wire logic [sfp_pkg::WIN_W-1:0]      max_freq_khz,
  output logic                                out_valid,
  output sfp_pkg::prep_t                      out_word
);

  sfp_pkg::prep_t word_next;

  // window and zero-pfd check, octave count and shift up into the vco range
  always_comb begin
    sfp_pkg::vco_t               fext;
    logic [sfp_pkg::CODE_W-1:0]  cnt;
    fext = sfp_pkg::VCO_W'(freq_khz);
    cnt  = '0;
    for (int i = 0; i < sfp_pkg::NUM_OCT; i++) begin
      cnt = cnt + sfp_pkg::CODE_W'(fext <= sfp_pkg::octave_khz(sfp_pkg::CODE_W'(i)));
    end
    word_next.oor  = (fext < sfp_pkg::VCO_W'(min_freq_khz)) ||
                     (fext > sfp_pkg::VCO_W'(max_freq_khz)) ||
                     (pfd_khz == '0);
    word_next.code = cnt;
    word_next.vco  = fext << cnt;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sfp_int_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sfp_int_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic [sfp_pkg::PFD_W-1:0] pfd_khz,
  input  wire logic                      in_valid,
  input  wire sfp_pkg::prep_t            in_word,
  output logic                           out_valid,
  output sfp_pkg::idiv_t                 out_word
);

  localparam int STAGES = sfp_pkg::VCO_W;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  function automatic sfp_pkg::idiv_t div_step(input sfp_pkg::idiv_t s,
                                              input logic [sfp_pkg::PFD_W-1:0] d);
    sfp_pkg::idiv_t           r;
    logic [sfp_pkg::PFD_W:0]  t;
    logic [sfp_pkg::PFD_W:0]  diff;
    logic                     qb;
    r    = s;
    t    = {s.rem, s.acc[sfp_pkg::VCO_W-1]};
    diff = t - {1'b0, d};
    qb   = (t >= {1'b0, d});
    r.rem = qb ? diff[sfp_pkg::PFD_W-1:0] : t[sfp_pkg::PFD_W-1:0];
    r.acc = {s.acc[sfp_pkg::VCO_W-2:0], qb};
    return r;
  endfunction

  sfp_pkg::idiv_t      stg [STAGES];
  sfp_pkg::idiv_t      src [STAGES];
  logic [STAGES-1:0]   vld;

  // stage inputs: the first takes the vco word, the rest their neighbor
  always_comb begin
    src[0].oor  = in_word.oor;
    src[0].code = in_word.code;
    src[0].rem  = '0;
    src[0].acc  = in_word.vco;
    for (int k = 1; k < STAGES; k++) begin
      src[k] = stg[k-1];
    end
  end

  // valid bits move with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // divider stages, one quotient bit each
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        stg[k] <= div_step(src[k], pfd_khz);
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_word  = stg[STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/sfp_frac_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sfp_frac_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic [sfp_pkg::PFD_W-1:0] pfd_khz,
  input  wire logic [sfp_pkg::MOD_W-1:0] fraction_modulus,
  input  wire logic                      in_valid,
  input  wire sfp_pkg::idiv_t            in_word,
  output logic                           out_valid,
  output sfp_pkg::result_t               out_word
);

  localparam int STAGES = sfp_pkg::FRAC_QW;

  // one restoring step against the doubled pfd
  function automatic sfp_pkg::fdiv_t div_step(input sfp_pkg::fdiv_t s,
                                              input logic [sfp_pkg::DEN_W-1:0] d);
    sfp_pkg::fdiv_t           r;
    logic [sfp_pkg::DEN_W:0]  t;
    logic [sfp_pkg::DEN_W:0]  diff;
    logic                     qb;
    r    = s;
    t    = {s.rem, s.acc[sfp_pkg::FRAC_QW-1]};
    diff = t - {1'b0, d};
    qb   = (t >= {1'b0, d});
    r.rem = qb ? diff[sfp_pkg::DEN_W-1:0] : t[sfp_pkg::DEN_W-1:0];
    r.acc = {s.acc[sfp_pkg::FRAC_QW-2:0], qb};
    return r;
  endfunction

  logic                          m_vld;
  sfp_pkg::mul_t                 m_word;
  logic                          a_vld;
  sfp_pkg::num_t                 a_word;
  logic [STAGES-1:0]             vld;
  sfp_pkg::fdiv_t                stg [STAGES];
  sfp_pkg::fdiv_t                src [STAGES];
  logic [sfp_pkg::DEN_W-1:0]     den;

  assign den = {pfd_khz, 1'b0};

  // valid bits for product, numerator and divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      a_vld <= 1'b0;
      vld   <= '0;
    end else if (adv) begin
      m_vld <= in_valid;
      a_vld <= m_vld;
      vld   <= {vld[STAGES-2:0], a_vld};
    end
  end

  // remainder times modulus
  always_ff @(posedge clk) begin
    if (adv) begin
      m_word.oor  <= in_word.oor;
      m_word.code <= in_word.code;
      m_word.n    <= in_word.acc;
      m_word.prod <= sfp_pkg::PROD_W'(in_word.rem) * sfp_pkg::PROD_W'(fraction_modulus);
    end
  end

  // rounding numerator: twice the product plus pfd
  always_ff @(posedge clk) begin
    if (adv) begin
      a_word.oor  <= m_word.oor;
      a_word.code <= m_word.code;
      a_word.n    <= m_word.n;
      a_word.num  <= sfp_pkg::NUM_W'({m_word.prod, 1'b0}) + sfp_pkg::NUM_W'(pfd_khz);
    end
  end

  // quotient stays below 2^FRAC_QW, so the upper numerator bits start below den
  always_comb begin
    src[0].oor  = a_word.oor;
    src[0].code = a_word.code;
    src[0].n    = a_word.n;
    src[0].rem  = a_word.num[sfp_pkg::FRAC_QW +: sfp_pkg::DEN_W];
    src[0].acc  = a_word.num[sfp_pkg::FRAC_QW-1:0];
    for (int k = 1; k < STAGES; k++) begin
      src[k] = stg[k-1];
    end
  end

  // fraction divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        stg[k] <= div_step(src[k], den);
      end
    end
  end

  // carry into n, saturation and out of range clearing
  always_comb begin
    sfp_pkg::fdiv_t                last;
    logic [sfp_pkg::MOD_W-1:0]     frac;
    logic                          carry;
    logic [sfp_pkg::VCO_W:0]       n1;
    last  = stg[STAGES-1];
    frac  = '0;
    carry = 1'b0;
    if (fraction_modulus != '0) begin
      if (last.acc >= fraction_modulus) begin
        frac  = last.acc - fraction_modulus;
        carry = 1'b1;
      end else begin
        frac  = last.acc;
      end
    end
    n1 = {1'b0, last.n} + (sfp_pkg::VCO_W + 1)'(carry);
    if (last.oor) begin
      out_word.integer_part = '0;
      out_word.fraction     = '0;
      out_word.divider_code = '0;
      out_word.out_of_range = 1'b1;
    end else if (n1 > (sfp_pkg::VCO_W + 1)'(sfp_pkg::INT_SAT)) begin
      out_word.integer_part = sfp_pkg::INT_SAT;
      out_word.fraction     = (fraction_modulus == '0) ? '0 :
                              fraction_modulus - sfp_pkg::MOD_W'(1);
      out_word.divider_code = last.code;
      out_word.out_of_range = 1'b0;
    end else begin
      out_word.integer_part = n1[sfp_pkg::INT_W-1:0];
      out_word.fraction     = frac;
      out_word.divider_code = last.code;
      out_word.out_of_range = 1'b0;
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/synth_frequency_planner_top.sv
// Frequency planner for a fractional-N synthesizer: each word on the input
// channel is a requested output frequency in kHz, and each word on the output
// channel is its plan (integer ratio N, fraction over the modulus rounded half
// up, power-of-two output divider code, out-of-range flag), one result per
// request, in order. A new request is taken every cycle while in_stall is low.
// The integer divider works on a VCO_W-bit word, VCO_W being the larger of
// FREQ_WIDTH and 23, and resolves one quotient bit per pipeline stage; the
// 12-stage fraction divider sits behind it. A two-word
// output buffer lets the pipeline keep taking requests while a result waits;
// in_stall rises only when that buffer is full.
// Configuration registers are written over the cfg channel, always ready, and
// must only change while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module synth_frequency_planner_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sfp_pkg::FREQ_WIDTH-1:0]   freq_khz,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [sfp_pkg::INT_W-1:0]             integer_part,
  output logic [sfp_pkg::MOD_W-1:0]             fraction,
  output logic [sfp_pkg::CODE_W-1:0]            divider_code,
  output logic                                  out_of_range,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfp_pkg::WIN_W-1:0]        cfg_data
);

  logic [sfp_pkg::PFD_W-1:0]  pfd_khz;
  logic [sfp_pkg::MOD_W-1:0]  fraction_modulus;
  logic [sfp_pkg::WIN_W-1:0]  min_freq_khz;
  logic [sfp_pkg::WIN_W-1:0]  max_freq_khz;

  logic                       adv;
  logic                       prep_valid;
  sfp_pkg::prep_t             prep_word;
  logic                       idiv_valid;
  sfp_pkg::idiv_t             idiv_word;
  logic                       res_valid;
  sfp_pkg::result_t           res_word;

  logic                       skid_valid;
  sfp_pkg::result_t           head;
  sfp_pkg::result_t           skid;
  logic                       out_valid_next;
  logic                       skid_valid_next;
  sfp_pkg::result_t           head_next;
  sfp_pkg::result_t           skid_next;
  logic                       push;
  logic                       pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pfd_khz          <= sfp_pkg::PFD_RESET;
      fraction_modulus <= sfp_pkg::MOD_RESET;
      min_freq_khz     <= sfp_pkg::MIN_RESET;
      max_freq_khz     <= sfp_pkg::MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (sfp_pkg::cfg_reg_t'(cfg_index))
        sfp_pkg::REG_PFD: pfd_khz          <= cfg_data[sfp_pkg::PFD_W-1:0];
        sfp_pkg::REG_MOD: fraction_modulus <= cfg_data[sfp_pkg::MOD_W-1:0];
        sfp_pkg::REG_MIN: min_freq_khz     <= cfg_data;
        sfp_pkg::REG_MAX: max_freq_khz     <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole pipeline moves unless the output buffer is full
  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  sfp_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .freq_khz     (freq_khz),
    .pfd_khz      (pfd_khz),
    .min_freq_khz (min_freq_khz),
    .max_freq_khz (max_freq_khz),
    .out_valid    (prep_valid),
    .out_word     (prep_word)
  );

  sfp_int_div u_int_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .pfd_khz   (pfd_khz),
    .in_valid  (prep_valid),
    .in_word   (prep_word),
    .out_valid (idiv_valid),
    .out_word  (idiv_word)
  );

  sfp_frac_div u_frac_div (
    .clk              (clk),
    .rst              (rst),
    .adv              (adv),
    .pfd_khz          (pfd_khz),
    .fraction_modulus (fraction_modulus),
    .in_valid         (idiv_valid),
    .in_word          (idiv_word),
    .out_valid        (res_valid),
    .out_word         (res_word)
  );

  // two-word output buffer: head drives the ports, skid catches one more
  assign push = adv && res_valid;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    head_next       = head;
    skid_next       = skid;
    if (pop) begin
      head_next       = skid;
      out_valid_next  = skid_valid;
      skid_valid_next = 1'b0;
    end
    if (push) begin
      if (!out_valid_next) begin
        head_next      = res_word;
        out_valid_next = 1'b1;
      end else begin
        skid_next       = res_word;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    skid <= skid_next;
  end

  assign integer_part = head.integer_part;
  assign fraction     = head.fraction;
  assign divider_code = head.divider_code;
  assign out_of_range = head.out_of_range;

endmodule
`default_nettype wire

FILE: rtl/sfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "synth_frequency_planner_top_assert.svh"
module sfp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [sfp_pkg::INT_W-1:0]      integer_part,
  input wire logic [sfp_pkg::MOD_W-1:0]      fraction,
  input wire logic [sfp_pkg::CODE_W-1:0]     divider_code,
  input wire logic                           out_of_range
);

  // a rejected request carries no plan
  `SFP_ASSERT_NOW(a_oor_clear, clk, rst, out_valid && out_of_range, (integer_part == '0) && (fraction == '0) && (divider_code == '0), "out of range word has nonzero plan fields")

  // divider code never exceeds the last octave
  `SFP_ASSERT_NOW(a_code_max, clk, rst, out_valid, divider_code <= sfp_pkg::MAX_CODE, "divider code beyond last octave")

  // the input stalls only while a result is being held
  `SFP_ASSERT_NOW(a_stall_held, clk, rst, in_stall, out_valid, "input stalled with no result held")

  // a taken result always frees room for the next request
  `SFP_ASSERT_NEXT(a_pop_frees, clk, rst, out_valid && !out_stall, !in_stall, "input still stalled after a result was taken")

endmodule

bind synth_frequency_planner_top sfp_checker u_sfp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .integer_part (integer_part),
  .fraction     (fraction),
  .divider_code (divider_code),
  .out_of_range (out_of_range)
);
`default_nettype wire

FILE: tb/synth_frequency_planner_checker.sv
`timescale 1ns / 1ps
module synth_frequency_planner_checker
  import sfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [FREQ_WIDTH-1:0]  freq_khz,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [INT_W-1:0]       integer_part,
  input  logic [MOD_W-1:0]       fraction,
  input  logic [CODE_W-1:0]      divider_code,
  input  logic                   out_of_range,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WIN_W-1:0]       cfg_data,
  output int                     bad_plans,
  output int                     plans_waiting
);

  // upper edge of each octave, smallest first; equal counts toward the larger divider
  localparam int unsigned OCTAVE_TOP [6] = '{68750, 137500, 275000, 550000, 1100000, 2200000};

  typedef struct packed {
    logic [FREQ_WIDTH-1:0] freq;
    result_t               plan;
  } plan_due_t;

  // shadow copy of the configuration registers
  logic [PFD_W-1:0] pfd_khz_q  = PFD_RESET;
  logic [MOD_W-1:0] modulus_q  = MOD_RESET;
  logic [WIN_W-1:0] win_min_q  = MIN_RESET;
  logic [WIN_W-1:0] win_max_q  = MAX_RESET;

  plan_due_t plans_due [$];

  initial begin
    bad_plans     = 0;
    plans_waiting = 0;
  end

  // frequency plan for one request under the current settings
  function automatic result_t plan_for_freq(input logic [FREQ_WIDTH-1:0] f);
    result_t           r;
    logic [CODE_W-1:0] code;
    longint unsigned   pfd, md, vco, n, rem, frac;
    r = '0;
    pfd = longint'(pfd_khz_q);
    md  = longint'(modulus_q);
    if (f < win_min_q || f > win_max_q || pfd == 0) begin
      r.out_of_range = 1'b1;
      return r;
    end
    code = '0;
    for (int i = 5; i >= 0; i--) begin
      if (f <= OCTAVE_TOP[i]) code = CODE_W'(6 - i);
    end
    vco = longint'(f) << code;
    n   = vco / pfd;
    rem = vco % pfd;
    // round half up, a full modulus carries into N
    if (md == 0) begin
      frac = 0;
    end else begin
      frac = (2 * rem * md + pfd) / (2 * pfd);
      if (frac >= md) begin
        frac = frac - md;
        n = n + 1;
      end
    end
    // saturate the ratio
    if (n > 65535) begin
      n = 65535;
      frac = (md == 0) ? 0 : md - 1;
    end
    r.integer_part = INT_W'(n);
    r.fraction     = MOD_W'(frac);
    r.divider_code = code;
    return r;
  endfunction

  always @(posedge clk) begin
    plan_due_t due;
    result_t   got;
    if (rst) begin
      pfd_khz_q = PFD_RESET;
      modulus_q = MOD_RESET;
      win_min_q = MIN_RESET;
      win_max_q = MAX_RESET;
      plans_due.delete();
      plans_waiting = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PFD: pfd_khz_q = cfg_data[PFD_W-1:0];
          REG_MOD: modulus_q = cfg_data[MOD_W-1:0];
          REG_MIN: win_min_q = cfg_data;
          REG_MAX: win_max_q = cfg_data;
          default: ;
        endcase
      end
      // compare an accepted result word with the oldest plan due
      if (out_valid && !out_stall) begin
        got = '{integer_part, fraction, divider_code, out_of_range};
        if (plans_due.size() == 0) begin
          bad_plans++;
          if (bad_plans <= 10)
            $display("%0t: result word with no request waiting: N=%0d frac=%0d code=%0d oor=%0b",
                     $realtime, integer_part, fraction, divider_code, out_of_range);
        end else begin
          due = plans_due.pop_front();
          if (got.integer_part !== due.plan.integer_part || got.fraction !== due.plan.fraction ||
              got.divider_code !== due.plan.divider_code ||
              got.out_of_range !== due.plan.out_of_range) begin
            bad_plans++;
            if (bad_plans <= 10)
              $display("%0t: freq %0d: exp N=%0d frac=%0d code=%0d oor=%0b, got N=%0d frac=%0d code=%0d oor=%0b",
                       $realtime, due.freq, due.plan.integer_part, due.plan.fraction,
                       due.plan.divider_code, due.plan.out_of_range, got.integer_part,
                       got.fraction, got.divider_code, got.out_of_range);
          end
        end
      end
      // accepted request word
      if (in_valid && !in_stall) begin
        due.freq = freq_khz;
        due.plan = plan_for_freq(freq_khz);
        plans_due.push_back(due);
      end
      plans_waiting = plans_due.size();
    end
  end

endmodule

FILE: tb/synth_frequency_planner_top_tb.sv
`timescale 1ns / 1ps
module synth_frequency_planner_top_tb;
  import sfp_pkg::*;

  localparam int unsigned OCTAVE_TOP [6] = '{68750, 137500, 275000, 550000, 1100000, 2200000};
  localparam int unsigned FREQ_TOP = (1 << FREQ_WIDTH) - 1;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FREQ_WIDTH-1:0] freq_khz = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [INT_W-1:0]      integer_part;
  logic [MOD_W-1:0]      fraction;
  logic [CODE_W-1:0]     divider_code;
  logic                  out_of_range;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [WIN_W-1:0]      cfg_data = '0;

  int          bad_plans;
  int          plans_waiting;
  int unsigned win_lo = 34375;
  int unsigned win_hi = 4400000;
  int unsigned burst_left = 0;
  int unsigned stall_cycle = 0;
  stall_mode_t stall_mode = STALL_NONE;

  synth_frequency_planner_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .freq_khz     (freq_khz),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .integer_part (integer_part),
    .fraction     (fraction),
    .divider_code (divider_code),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  synth_frequency_planner_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .freq_khz      (freq_khz),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .integer_part  (integer_part),
    .fraction      (fraction),
    .divider_code  (divider_code),
    .out_of_range  (out_of_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .bad_plans     (bad_plans),
    .plans_waiting (plans_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("synth_frequency_planner_top_tb: FAIL");
    $finish;
  end

  // result side stalls, switching to a random pattern whenever the low eight bits of stall_cycle are zero
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle[7:0] == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_cycle[2:0] < 3'd5);
    endcase
  end

  // one request word, sent in bursts with random gaps between them
  task automatic request_plan(input logic [FREQ_WIDTH-1:0] f);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    freq_khz <= f;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // hold requests until every plan has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (plans_waiting != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [WIN_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
  endtask

  // settings of one phase: fixed corners first, random ones after
  task automatic program_phase(input int ph);
    logic [PFD_W-1:0] pfd;
    logic [MOD_W-1:0] md;
    int unsigned      lo, hi;
    pfd = PFD_W'($urandom_range(1000, 105000));
    md  = MOD_W'($urandom_range(2, 4095));
    lo  = 0;
    hi  = FREQ_TOP;
    case (ph)
      1: begin
        pfd = PFD_W'(105000);
        md  = MOD_W'(4095);
      end
      2: begin
        pfd = PFD_W'(1000);
        md  = MOD_W'(2);
      end
      3: pfd = '0;
      4: md = '0;
      5: md = MOD_W'(1);
      6: pfd = PFD_W'(1);
      7: begin
        lo = 5000000;
        hi = 100;
      end
      8: pfd = PFD_W'(100);
      9: begin
        lo = $urandom_range(34375, 4400000);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(0, 3000000);
        hi = lo + $urandom_range(0, FREQ_TOP - 3000000);
      end
    endcase
    win_lo = lo;
    win_hi = hi;
    // junk above the narrow registers must be dropped
    write_reg(REG_PFD, {(WIN_W-PFD_W)'($urandom), pfd});
    write_reg(REG_MOD, {(WIN_W-MOD_W)'($urandom), md});
    write_reg(REG_MIN, WIN_W'(lo));
    write_reg(REG_MAX, WIN_W'(hi));
    cfg_valid <= 1'b0;
  endtask

  // random request: inside the window for half the picks, else at octave or window edges or anywhere
  function automatic logic [FREQ_WIDTH-1:0] pick_freq();
    int unsigned sel;
    int unsigned f;
    sel = $urandom_range(0, 9);
    if (sel < 2 || (sel >= 5 && win_lo > win_hi)) begin
      f = $urandom;
    end else if (sel < 4) begin
      f = OCTAVE_TOP[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2;
    end else if (sel == 4) begin
      f = ($urandom_range(0, 1) ? win_lo : win_hi) + $urandom_range(0, 4) - 2;
    end else begin
      f = win_lo + $urandom % (win_hi - win_lo + 1);
    end
    return FREQ_WIDTH'(f);
  endfunction

  initial begin
    int unsigned corner [18] = '{0, 34374, 34375, 68750, 68751, 137500, 137501, 275000,
                                 275001, 550000, 550001, 1100000, 1100001, 2200000,
                                 2200001, 4400000, 4400001, FREQ_TOP};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window edges and octave edges
    foreach (corner[i]) request_plan(FREQ_WIDTH'(corner[i]));
    repeat (30) request_plan(pick_freq());

    for (int ph = 1; ph <= 21; ph++) begin
      wait_idle();
      program_phase(ph);
      repeat ((ph <= 9) ? 40 : 50) request_plan(pick_freq());
    end

    wait_idle();
    repeat (60) @(posedge clk);
    @(negedge clk);
    if (bad_plans == 0 && plans_waiting == 0) begin
      $display("synth_frequency_planner_top_tb: PASS");
    end else begin
      $display("synth_frequency_planner_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: synth_frequency_planner_top.f
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_prep.sv
rtl/sfp_int_div.sv
rtl/sfp_frac_div.sv
rtl/synth_frequency_planner_top.sv
rtl/sfp_checker.sv
tb/synth_frequency_planner_checker.sv
tb/synth_frequency_planner_top_tb.sv
